### rtl/core/tagp_pkg.sv
// ----------------------------------------------------------------------------
// tagp_pkg
// Shared types, constants and helper functions of the GPU placement block.
// ----------------------------------------------------------------------------
package tagp_pkg;

   localparam int GPUS_PER_NODE = 8;
   localparam int KEEP_MIN      = 12;
   localparam int KEEP_SLACK    = 6;
   localparam int W_CROSS       = 100;
   localparam int W_FRAG        = 10;
   localparam int W_AWK         = 5;

   localparam logic [63:0] CAPS_RESET = 64'h8888888888888888;

   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_NODES = 2'd1;
   localparam logic [1:0] CSR_CAPS  = 2'd2;

   typedef enum logic [2:0] {
      ST_PLACED    = 3'd0,
      ST_INVALID   = 3'd1,
      ST_SHORT     = 3'd2,
      ST_WAIT      = 3'd3,
      ST_NOTFOUND  = 3'd4,
      ST_RELEASED  = 3'd5
   } status_type;

   typedef struct packed {
      logic       load;
      logic       release_op;
      logic       fail;
      status_type fail_code;
      logic       sweep;
      logic       minn_step;
      logic       comb_init;
      logic       eval_step;
      logic       cmp_next;
      logic       emit_init;
      logic       emit_step;
   } cmd_type;

   typedef struct packed {
      logic is_release;
      logic zero_count;
      logic sweep_done;
      logic short_total;
      logic topo;
      logic minn_done;
      logic minn_short;
      logic frag_wait;
      logic eval_done;
      logic comb_last;
      logic found_any;
      logic out_free;
      logic emit_last;
   } sts_type;

   function automatic logic [3:0] cap_clip(input logic [3:0] nib);
      return (nib > 4'(GPUS_PER_NODE)) ? 4'(GPUS_PER_NODE) : nib;
   endfunction

   function automatic logic [7:0] cap_mask(input logic [3:0] nib);
      logic [8:0] m;
      m = (9'd1 << cap_clip(nib)) - 9'd1;
      return m[7:0];
   endfunction

   function automatic logic [3:0] pop8(input logic [7:0] m);
      logic [3:0] c;
      c = '0;
      for (int b = 0; b < 8; b++) c = c + {3'd0, m[b]};
      return c;
   endfunction

   // lowest t set bits of m
   function automatic logic [7:0] take_low(input logic [7:0] m, input logic [3:0] t);
      logic [7:0] r;
      logic [3:0] left;
      r = '0;
      left = t;
      for (int b = 0; b < 8; b++) begin
         if (m[b] && left != 4'd0) begin
            r[b] = 1'b1;
            left = left - 4'd1;
         end
      end
      return r;
   endfunction

   function automatic logic odd_leftover(input logic [3:0] left);
      return left == 4'd3 || left == 4'd5 || left == 4'd6 || left == 4'd7;
   endfunction

endpackage

### rtl/core/topology_aware_gpu_placement.sv
// ----------------------------------------------------------------------------
// topology_aware_gpu_placement
// GPU placement engine. Keeps a free mask per node, places requests first-fit
// or on the fewest nodes, scored over candidate node sets, and frees GPUs on
// release. An item is taken only when the engine is idle. A release or a zero
// count goes straight to its result; any other request first sweeps all nodes,
// and one short of free GPUs ends there. A first-fit placement then visits the
// nodes in order; a topology placement finds the minimum node count (or ends in
// a fragmentation wait) and scores each node set of that size among the kept
// candidates (up to C(16,10) = 8008), node by node, the sequencer and one shared
// packing unit visiting the sets one after another. Each result waits in an
// output register until taken; configuration writes are accepted at any cycle
// and take effect at once.
// ----------------------------------------------------------------------------
module topology_aware_gpu_placement #(
   parameter int NODES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // gpu_count, jobs_running, release_node, release_mask
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // alloc_node, alloc_mask, degraded, placement_score
   output logic [2:0]  rsp_tuser,   // status
   output logic        rsp_tlast
);
   import tagp_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [3:0]  alloc_node;
   logic [7:0]  alloc_mask;
   logic        degraded;
   logic [10:0] score;

   assign csr_ready = 1'b1;

   tagp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tagp_dp #(.NODES(NODES)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .in_command      (req_tuser),
      .in_gpu_count    (req_tdata[7:0]),
      .in_jobs_running (req_tdata[8]),
      .in_release_node (req_tdata[12:9]),
      .in_release_mask (req_tdata[20:13]),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (rsp_tuser),
      .rsp_alloc_node  (alloc_node),
      .rsp_alloc_mask  (alloc_mask),
      .rsp_degraded    (degraded),
      .rsp_score       (score),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {score, degraded, alloc_mask, alloc_node};

endmodule

### rtl/core/tagp_ctrl.sv
// ----------------------------------------------------------------------------
// tagp_ctrl
// Sequencer of the placement engine: dispatches an item, steps the sweep,
// the minimum node count, the node set search and the result emission.
// ----------------------------------------------------------------------------
module tagp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  tagp_pkg::sts_type sts,
   output tagp_pkg::cmd_type cmd
);
   import tagp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_REL, S_ERR, S_SWEEP, S_CHECK,
      S_MINN, S_DECIDE, S_EVAL, S_CMP, S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   status_type err_ff, err_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      cmd      = '0;
      cmd.fail_code = err_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (sts.is_release) begin
               state_in = S_REL;
            end else if (sts.zero_count) begin
               err_in   = ST_INVALID;
               state_in = S_ERR;
            end else begin
               state_in = S_SWEEP;
            end
         end
         S_REL: begin
            if (sts.out_free) begin
               cmd.release_op = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ERR: begin
            if (sts.out_free) begin
               cmd.fail = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.short_total) begin
               err_in   = ST_SHORT;
               state_in = S_ERR;
            end else if (!sts.topo) begin
               cmd.emit_init = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_MINN;
            end
         end
         S_MINN: begin
            if (sts.minn_done) begin
               if (sts.minn_short) begin
                  err_in   = ST_SHORT;
                  state_in = S_ERR;
               end else begin
                  state_in = S_DECIDE;
               end
            end else begin
               cmd.minn_step = 1'b1;
            end
         end
         S_DECIDE: begin
            if (sts.frag_wait) begin
               err_in   = ST_WAIT;
               state_in = S_ERR;
            end else begin
               cmd.comb_init = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (sts.eval_done) state_in = S_CMP;
            else cmd.eval_step = 1'b1;
         end
         S_CMP: begin
            cmd.cmp_next = 1'b1;
            if (sts.comb_last) begin
               if (sts.found_any) begin
                  cmd.emit_init = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  err_in   = ST_NOTFOUND;
                  state_in = S_ERR;
               end
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_step = 1'b1;
               if (sts.emit_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff   <= ST_PLACED;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

endmodule

### rtl/core/tagp_dp.sv
// ----------------------------------------------------------------------------
// tagp_dp
// Datapath: settings, free masks, sorted candidate list, node set search
// registers, packing arithmetic and the result register.
// ----------------------------------------------------------------------------
module tagp_dp #(
   parameter int NODES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_data,
   input  logic              in_command,
   input  logic [7:0]        in_gpu_count,
   input  logic              in_jobs_running,
   input  logic [3:0]        in_release_node,
   input  logic [7:0]        in_release_mask,
   input  tagp_pkg::cmd_type cmd,
   output tagp_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [3:0]        rsp_alloc_node,
   output logic [7:0]        rsp_alloc_mask,
   output logic              rsp_degraded,
   output logic [10:0]       rsp_score,
   output logic              rsp_last
);
   import tagp_pkg::*;

   localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;

   logic        mode_ff;
   logic [4:0]  niu_ff;
   logic [63:0] caps_ff;
   logic [7:0]  free_ff [NODES];

   logic        cmdin_ff, run_ff;
   logic [7:0]  g_ff, rmask_ff;
   logic [3:0]  rnode_ff;

   logic [4:0]  sw_ptr_ff, nc_ff, mn_ptr_ff, minn_ff, keep_ff, ev_ptr_ff, e_ptr_ff;
   logic [7:0]  total_ff, cov_ff, rem_ff;
   logic [3:0]  maxcap_ff;
   logic [3:0]  cidx_ff  [NODES];
   logic [3:0]  cfree_ff [NODES];
   logic [3:0]  comb_ff  [NODES];
   logic [3:0]  bcomb_ff [NODES];
   logic        deg_ff, found_ff;
   logic [10:0] score_ff, bscore_ff;

   logic        o_valid_ff, o_deg_ff, o_last_ff;
   logic [2:0]  o_status_ff;
   logic [3:0]  o_node_ff;
   logic [7:0]  o_mask_ff;
   logic [10:0] o_score_ff;

   logic [4:0]  np;
   logic [3:0]  emit_node, rd_node, rd_cnt;
   logic [7:0]  rd_free, rd_avail, rd_cmask;

   // sweep insert lanes
   logic        ge [NODES];
   logic [3:0]  ins_idx  [NODES];
   logic [3:0]  ins_free [NODES];

   // minimum node decision
   logic [3:0]  mc;
   logic [8:0]  prod;
   logic        wait_cond;
   logic [4:0]  k0, keep_val;

   // evaluation
   logic [3:0]  ev_pos, ev_f, ev_left;
   logic [7:0]  ev_t;
   logic [10:0] ev_score;

   // next combination
   logic        better, have_piv;
   logic [4:0]  piv, lim;
   logic [3:0]  comb_next [NODES];

   // emission
   logic [7:0]  em_t, em_mask;
   logic        em_write, em_last;

   assign np = (niu_ff > 5'(NODES)) ? 5'(NODES) : niu_ff;

   assign emit_node = mode_ff ? cidx_ff[bcomb_ff[e_ptr_ff[IW-1:0]][IW-1:0]] : e_ptr_ff[3:0];

   always_comb begin
      if (cmd.sweep) rd_node = sw_ptr_ff[3:0];
      else if (cmd.emit_step) rd_node = emit_node;
      else rd_node = rnode_ff;
   end

   assign rd_free  = free_ff[rd_node[IW-1:0]];
   assign rd_cmask = cap_mask(caps_ff[{rd_node, 2'b00} +: 4]);
   assign rd_avail = rd_free & rd_cmask;
   assign rd_cnt   = pop8(rd_avail);

   always_comb begin
      for (int p = 0; p < NODES; p++) begin
         ge[p] = (5'(p) < nc_ff) && (cfree_ff[p] >= rd_cnt);
      end
      for (int p = 0; p < NODES; p++) begin
         if (ge[p]) begin
            ins_idx[p]  = cidx_ff[p];
            ins_free[p] = cfree_ff[p];
         end else if (p == 0 || ge[(p > 0) ? p - 1 : 0]) begin
            ins_idx[p]  = sw_ptr_ff[3:0];
            ins_free[p] = rd_cnt;
         end else begin
            ins_idx[p]  = cidx_ff[(p > 0) ? p - 1 : 0];
            ins_free[p] = cfree_ff[(p > 0) ? p - 1 : 0];
         end
      end
   end

   assign mc        = (maxcap_ff == 4'd0) ? 4'd1 : maxcap_ff;
   assign prod      = 9'(minn_ff - 5'd1) * 9'(mc);
   assign wait_cond = prod >= {1'b0, g_ff};
   assign k0        = (minn_ff + 5'(KEEP_SLACK) > 5'(KEEP_MIN)) ?
                      minn_ff + 5'(KEEP_SLACK) : 5'(KEEP_MIN);
   assign keep_val  = (k0 > nc_ff) ? nc_ff : k0;

   assign ev_pos  = comb_ff[ev_ptr_ff[IW-1:0]];
   assign ev_f    = cfree_ff[ev_pos[IW-1:0]];
   assign ev_t    = (rem_ff < {4'd0, ev_f}) ? rem_ff : {4'd0, ev_f};
   assign ev_left = ev_f - ev_t[3:0];
   assign ev_score = score_ff
                   + ((ev_ptr_ff != 5'd0) ? 11'(W_CROSS) : 11'd0)
                   + ((ev_left != 4'd0)   ? 11'(W_FRAG)  : 11'd0)
                   + (odd_leftover(ev_left) ? 11'(W_AWK) : 11'd0);

   assign better = (rem_ff == 8'd0) && (!found_ff || score_ff < bscore_ff);

   always_comb begin
      have_piv = 1'b0;
      piv      = '0;
      for (int p = 0; p < NODES; p++) begin
         lim = keep_ff - minn_ff + 5'(p);
         if (5'(p) < minn_ff && {1'b0, comb_ff[p]} != lim) begin
            have_piv = 1'b1;
            piv      = 5'(p);
         end
      end
      lim = '0;
      for (int q = 0; q < NODES; q++) begin
         if (5'(q) == piv) comb_next[q] = comb_ff[q] + 4'd1;
         else if (5'(q) > piv && 5'(q) < minn_ff)
            comb_next[q] = 4'(5'(comb_ff[piv[IW-1:0]]) + 5'd1 + 5'(q) - piv);
         else comb_next[q] = comb_ff[q];
      end
   end

   assign em_t     = (rem_ff < {4'd0, rd_cnt}) ? rem_ff : {4'd0, rd_cnt};
   assign em_mask  = take_low(rd_avail, em_t[3:0]);
   assign em_write = cmd.emit_step && (rd_cnt != 4'd0);
   assign em_last  = (rem_ff == em_t);

   always_comb begin
      sts.is_release  = cmdin_ff;
      sts.zero_count  = (g_ff == 8'd0);
      sts.sweep_done  = (sw_ptr_ff == 5'(NODES - 1));
      sts.short_total = (total_ff < g_ff);
      sts.topo        = mode_ff;
      sts.minn_done   = !((mn_ptr_ff < nc_ff) && (cov_ff < g_ff));
      sts.minn_short  = (nc_ff == 5'd0) || (cov_ff < g_ff);
      sts.frag_wait   = wait_cond && run_ff;
      sts.eval_done   = (ev_ptr_ff == minn_ff) || (rem_ff == 8'd0);
      sts.comb_last   = !have_piv;
      sts.found_any   = found_ff || better;
      sts.out_free    = !o_valid_ff || rsp_ready;
      sts.emit_last   = em_write && em_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b1;
         niu_ff     <= 5'd16;
         caps_ff    <= CAPS_RESET;
         for (int p = 0; p < NODES; p++) free_ff[p] <= cap_mask(CAPS_RESET[4*p +: 4]);
         o_valid_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_MODE:  mode_ff <= csr_data[0];
               CSR_NODES: niu_ff  <= csr_data[4:0];
               CSR_CAPS: begin
                  caps_ff <= csr_data;
                  for (int p = 0; p < NODES; p++)
                     free_ff[p] <= free_ff[p] & cap_mask(csr_data[4*p +: 4]);
               end
               default: ;
            endcase
         end

         if (rsp_ready && !(cmd.release_op || cmd.fail || em_write)) o_valid_ff <= 1'b0;

         if (cmd.load) begin
            cmdin_ff  <= in_command;
            g_ff      <= in_gpu_count;
            run_ff    <= in_jobs_running;
            rnode_ff  <= in_release_node;
            rmask_ff  <= in_release_mask;
            rem_ff    <= in_gpu_count;
            sw_ptr_ff <= '0;
            total_ff  <= '0;
            maxcap_ff <= '0;
            nc_ff     <= '0;
            mn_ptr_ff <= '0;
            cov_ff    <= '0;
            minn_ff   <= '0;
         end

         if (cmd.release_op) begin
            if ({1'b0, rnode_ff} < np)
               free_ff[rnode_ff[IW-1:0]] <= rd_free | (rmask_ff & rd_cmask);
            o_valid_ff  <= 1'b1;
            o_status_ff <= ST_RELEASED;
            o_node_ff   <= rnode_ff;
            o_mask_ff   <= ({1'b0, rnode_ff} < np) ? (rmask_ff & rd_cmask) : 8'd0;
            o_deg_ff    <= 1'b0;
            o_score_ff  <= '0;
            o_last_ff   <= 1'b1;
         end

         if (cmd.fail) begin
            o_valid_ff  <= 1'b1;
            o_status_ff <= cmd.fail_code;
            o_node_ff   <= '0;
            o_mask_ff   <= '0;
            o_deg_ff    <= 1'b0;
            o_score_ff  <= '0;
            o_last_ff   <= 1'b1;
         end

         if (cmd.sweep) begin
            sw_ptr_ff <= sw_ptr_ff + 5'd1;
            if (sw_ptr_ff < np) begin
               total_ff <= total_ff + {4'd0, rd_cnt};
               if (cap_clip(caps_ff[{sw_ptr_ff[3:0], 2'b00} +: 4]) > maxcap_ff)
                  maxcap_ff <= cap_clip(caps_ff[{sw_ptr_ff[3:0], 2'b00} +: 4]);
               if (rd_cnt != 4'd0) begin
                  nc_ff <= nc_ff + 5'd1;
                  for (int p = 0; p < NODES; p++) begin
                     cidx_ff[p]  <= ins_idx[p];
                     cfree_ff[p] <= ins_free[p];
                  end
               end
            end
         end

         if (cmd.minn_step) begin
            cov_ff    <= cov_ff + {4'd0, cfree_ff[mn_ptr_ff[IW-1:0]]};
            minn_ff   <= minn_ff + 5'd1;
            mn_ptr_ff <= mn_ptr_ff + 5'd1;
         end

         if (cmd.comb_init) begin
            deg_ff    <= wait_cond;
            keep_ff   <= keep_val;
            found_ff  <= 1'b0;
            ev_ptr_ff <= '0;
            rem_ff    <= g_ff;
            score_ff  <= '0;
            for (int p = 0; p < NODES; p++) comb_ff[p] <= 4'(p);
         end

         if (cmd.eval_step) begin
            ev_ptr_ff <= ev_ptr_ff + 5'd1;
            rem_ff    <= rem_ff - ev_t;
            score_ff  <= ev_score;
         end

         if (cmd.cmp_next) begin
            if (better) begin
               found_ff  <= 1'b1;
               bscore_ff <= score_ff;
               for (int p = 0; p < NODES; p++) bcomb_ff[p] <= comb_ff[p];
            end
            for (int p = 0; p < NODES; p++) comb_ff[p] <= comb_next[p];
            ev_ptr_ff <= '0;
            rem_ff    <= g_ff;
            score_ff  <= '0;
         end

         if (cmd.emit_init) begin
            e_ptr_ff <= '0;
         end

         if (cmd.emit_step) begin
            e_ptr_ff <= e_ptr_ff + 5'd1;
            if (em_write) begin
               free_ff[rd_node[IW-1:0]] <= rd_free & ~em_mask;
               rem_ff      <= rem_ff - em_t;
               o_valid_ff  <= 1'b1;
               o_status_ff <= ST_PLACED;
               o_node_ff   <= rd_node;
               o_mask_ff   <= em_mask;
               o_deg_ff    <= mode_ff & deg_ff;
               o_score_ff  <= mode_ff ? bscore_ff : 11'd0;
               o_last_ff   <= em_last;
            end
         end
      end
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_status     = o_status_ff;
   assign rsp_alloc_node = o_node_ff;
   assign rsp_alloc_mask = o_mask_ff;
   assign rsp_degraded   = o_deg_ff;
   assign rsp_score      = o_score_ff;
   assign rsp_last       = o_last_ff;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the GPU placement block. Every place and release
// item is run through a cycle-free placement model kept here, and each result
// transfer is compared field by field against the expectation at the queue
// front. Directed tests cover errors, first fit, topology placement,
// fragmentation wait, degraded placement, release and capacity rewrites.
// Random phases follow, with sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import tagp_pkg::*;

   localparam int NNODE    = 16;
   localparam int WD_LIMIT = 600000;

   typedef struct packed {
      status_type  st;
      logic [3:0]  node;
      logic [7:0]  mask;
      logic        deg;
      logic [10:0] score;
      logic        last;
   } placement_t;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   topology_aware_gpu_placement #(.NODES(NNODE)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // placement model state
   logic        mdl_mode;
   logic [4:0]  mdl_nodes;
   logic [63:0] mdl_caps;
   logic [7:0]  mdl_free [NNODE];

   placement_t  alloc_q[$];
   int          mismatches;
   int          idle_pct;
   int          stall_pct;
   int          quiet_cycles;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic int node_cap(int n);
      int c;
      c = mdl_caps[4*n +: 4];
      return c > GPUS_PER_NODE ? GPUS_PER_NODE : c;
   endfunction

   function automatic logic [7:0] cap_bits(int n);
      logic [8:0] m;
      m = (9'd1 << node_cap(n)) - 9'd1;
      return m[7:0];
   endfunction

   function automatic int free_of(int n);
      return $countones(mdl_free[n] & cap_bits(n));
   endfunction

   function automatic logic [7:0] lowest_bits(logic [7:0] m, int t);
      logic [7:0] r;
      r = '0;
      for (int b = 0; b < 8; b++) begin
         if (m[b] && t > 0) begin
            r[b] = 1'b1;
            t--;
         end
      end
      return r;
   endfunction

   function automatic int nodes_present();
      return mdl_nodes > NNODE ? NNODE : int'(mdl_nodes);
   endfunction

   task automatic push_alloc(status_type st, int node, logic [7:0] mask, logic deg,
                             int score, logic last);
      placement_t e;
      e.st    = st;
      e.node  = 4'(node);
      e.mask  = mask;
      e.deg   = deg;
      e.score = 11'(score);
      e.last  = last;
      alloc_q.insert(alloc_q.size(), e);
   endtask

   task automatic model_csr(logic [1:0] idx, logic [63:0] val);
      if (idx == CSR_MODE) begin
         mdl_mode = val[0];
      end else if (idx == CSR_NODES) begin
         mdl_nodes = val[4:0];
      end else if (idx == CSR_CAPS) begin
         mdl_caps = val;
         for (int n = 0; n < NNODE; n++) mdl_free[n] &= cap_bits(n);
      end
   endtask

   task automatic model_place(int g, logic running);
      int         np, total, rem, f, t;
      int         cidx[NNODE], cfree[NNODE], comb[NNODE];
      int         bnode[NNODE], tn[NNODE];
      logic [7:0] bmask[NNODE], tm[NNODE], m;
      int         nc, covered, minn, maxcap, ideal, keep, bcnt, bscore;
      int         j, sum, cnt, frag, awk, sc, n;
      bit         found, deg;
      np = nodes_present();
      total = 0;
      for (int i = 0; i < np; i++) total += free_of(i);
      if (g == 0) begin
         push_alloc(ST_INVALID, 0, 0, 0, 0, 1);
         return;
      end
      if (total < g) begin
         push_alloc(ST_SHORT, 0, 0, 0, 0, 1);
         return;
      end
      if (mdl_mode == 1'b0) begin
         rem = g;
         for (int i = 0; i < np && rem > 0; i++) begin
            f = free_of(i);
            if (f == 0) continue;
            t = rem < f ? rem : f;
            m = lowest_bits(mdl_free[i] & cap_bits(i), t);
            mdl_free[i] &= ~m;
            rem -= t;
            push_alloc(ST_PLACED, i, m, 0, 0, rem == 0);
         end
         return;
      end
      nc = 0;
      maxcap = 0;
      for (int i = 0; i < np; i++) begin
         f = free_of(i);
         if (node_cap(i) > maxcap) maxcap = node_cap(i);
         if (f == 0) continue;
         j = nc;
         while (j > 0 && cfree[j-1] < f) begin
            cidx[j] = cidx[j-1];
            cfree[j] = cfree[j-1];
            j--;
         end
         cidx[j] = i;
         cfree[j] = f;
         nc++;
      end
      covered = 0;
      minn = 0;
      for (int i = 0; i < nc && covered < g; i++) begin
         covered += cfree[i];
         minn++;
      end
      if (nc == 0 || covered < g) begin
         push_alloc(ST_SHORT, 0, 0, 0, 0, 1);
         return;
      end
      if (maxcap < 1) maxcap = 1;
      ideal = (g + maxcap - 1) / maxcap;
      if (minn > ideal && running) begin
         push_alloc(ST_WAIT, 0, 0, 0, 0, 1);
         return;
      end
      deg = minn > ideal;
      keep = minn + KEEP_SLACK > KEEP_MIN ? minn + KEEP_SLACK : KEEP_MIN;
      if (keep > nc) keep = nc;
      for (int i = 0; i < minn; i++) comb[i] = i;
      found = 0;
      bcnt = 0;
      bscore = 0;
      while (1) begin
         sum = 0;
         rem = g;
         cnt = 0;
         frag = 0;
         awk = 0;
         for (int i = 0; i < minn; i++) sum += cfree[comb[i]];
         if (sum >= g) begin
            for (int i = 0; i < minn && rem > 0; i++) begin
               n = cidx[comb[i]];
               f = cfree[comb[i]];
               t = rem < f ? rem : f;
               tn[cnt] = n;
               tm[cnt] = lowest_bits(mdl_free[n] & cap_bits(n), t);
               cnt++;
               rem -= t;
               if (f - t > 0) frag++;
               if (f - t == 3 || f - t == 5 || f - t == 6 || f - t == 7) awk++;
            end
            if (cnt > 0 && rem == 0) begin
               sc = W_CROSS * (cnt - 1) + W_FRAG * frag + W_AWK * awk;
               if (!found || sc < bscore) begin
                  found = 1;
                  bscore = sc;
                  bcnt = cnt;
                  bnode = tn;
                  bmask = tm;
               end
            end
         end
         j = minn;
         while (j > 0 && comb[j-1] == keep - minn + (j - 1)) j--;
         if (j == 0) break;
         comb[j-1]++;
         for (int i = j; i < minn; i++) comb[i] = comb[i-1] + 1;
      end
      if (!found) begin
         push_alloc(ST_NOTFOUND, 0, 0, 0, 0, 1);
         return;
      end
      for (int i = 0; i < bcnt; i++) begin
         mdl_free[bnode[i]] &= ~bmask[i];
         push_alloc(ST_PLACED, bnode[i], bmask[i], deg, bscore, i + 1 == bcnt);
      end
   endtask

   task automatic model_item(logic cmd, int g, logic running, int rn, logic [7:0] rm);
      logic [7:0] m;
      if (cmd) begin
         m = '0;
         if (rn < nodes_present()) begin
            m = rm & cap_bits(rn);
            mdl_free[rn] |= m;
         end
         push_alloc(ST_RELEASED, rn, m, 0, 0, 1);
      end else begin
         model_place(g, running);
      end
   endtask

   task automatic send_item(logic cmd, int g, logic running, int rn, logic [7:0] rm);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'd0, rm, 4'(rn), running, 8'(g)};
      do @(posedge clock); while (!req_tready);
      model_item(cmd, g, running, rn, rm);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      model_csr(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (alloc_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic release_node(int n);
      send_item(1'b1, $urandom_range(255), $urandom_range(1), n, 8'hff);
   endtask

   // result checker
   always @(posedge clock) begin
      placement_t e;
      placement_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.st    = status_type'(rsp_tuser);
         got.node  = rsp_tdata[3:0];
         got.mask  = rsp_tdata[11:4];
         got.deg   = rsp_tdata[12];
         got.score = rsp_tdata[23:13];
         got.last  = rsp_tlast;
         if (alloc_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %p", got);
         end else begin
            e = alloc_q.pop_front();
            if (got !== e) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: exp %p got %p", e, got);
            end
         end
      end
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WD_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_errors();
      send_item(1'b0, 0, 1'b1, 15, 8'hff);
      send_item(1'b0, 255, 1'b1, 15, 8'hff);
      send_item(1'b0, 12, 1'b1, 0, 8'h00);
      send_item(1'b1, 0, 1'b0, 0, 8'hff);
      drain();
   endtask

   task automatic test_topology();
      write_csr(CSR_NODES, 64'd3);
      for (int n = 0; n < 3; n++) release_node(n);
      for (int n = 0; n < 3; n++) send_item(1'b0, 7, 1'b1, 0, 8'h00);
      send_item(1'b0, 2, 1'b1, 0, 8'h00);
      send_item(1'b0, 2, 1'b0, 0, 8'h00);
      send_item(1'b1, 0, 1'b0, 3, 8'hff);
      drain();
      write_csr(CSR_NODES, 64'd31);
      send_item(1'b0, 20, 1'b0, 0, 8'h00);
      drain();
   endtask

   task automatic test_first_fit();
      write_csr(CSR_MODE, 64'd0);
      write_csr(CSR_NODES, 64'd1);
      send_item(1'b0, 9, 1'b0, 0, 8'h00);
      send_item(1'b0, 3, 1'b0, 0, 8'h00);
      drain();
      write_csr(CSR_NODES, 64'd16);
      send_item(1'b0, 13, 1'b1, 0, 8'h00);
      drain();
   endtask

   task automatic test_capacity();
      write_csr(CSR_CAPS, 64'h0);
      send_item(1'b0, 1, 1'b0, 0, 8'h00);
      send_item(1'b1, 0, 1'b0, 5, 8'hff);
      drain();
      write_csr(CSR_CAPS, 64'hffff_ffff_ffff_ffff);
      write_csr(CSR_MODE, 64'd1);
      release_node(0);
      release_node(1);
      send_item(1'b0, 4, 1'b1, 0, 8'h00);
      drain();
   endtask

   task automatic random_csr();
      write_csr(CSR_MODE, 64'($urandom_range(1)));
      write_csr(CSR_NODES, ($urandom_range(3) == 0) ? 64'($urandom_range(31))
                                                    : 64'($urandom_range(16, 4)));
      if ($urandom_range(2) == 0) write_csr(CSR_CAPS, {$urandom, $urandom});
      else if ($urandom_range(1) == 0) write_csr(CSR_CAPS, CAPS_RESET);
      else write_csr(CSR_CAPS, 64'h7878_8786_5888_8488);
   endtask

   task automatic test_random(int count);
      int pick;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 65; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 33; stall_pct = 33; end
         endcase
         random_csr();
         for (int k = 0; k < count / 8; k++) begin
            pick = $urandom_range(99);
            if (pick < 42) begin
               send_item(1'b1, $urandom_range(255), $urandom_range(1),
                         $urandom_range(15), 8'($urandom_range(255)));
            end else if (pick < 92) begin
               send_item(1'b0, $urandom_range(12, 1), $urandom_range(1),
                         $urandom_range(15), 8'($urandom_range(255)));
            end else begin
               send_item(1'b0, $urandom_range(255), $urandom_range(1),
                         $urandom_range(15), 8'($urandom_range(255)));
            end
         end
         drain();
      end
   endtask

   initial begin
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      mismatches = 0;
      idle_pct   = 0;
      stall_pct  = 0;
      quiet_cycles = 0;
      mdl_mode  = 1'b1;
      mdl_nodes = 5'd16;
      mdl_caps  = CAPS_RESET;
      for (int n = 0; n < NNODE; n++) mdl_free[n] = cap_bits(n);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_errors();
      test_topology();
      test_first_fit();
      test_capacity();
      test_random(288);

      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && alloc_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
